// ===== rtl/wpm_pkg.sv =====
// Shared types and byte codes for the wildcard pattern matcher.
// No dependencies; imported by every module of the block.
package wpm_pkg;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;
   localparam logic [7:0] CH_QUOTE = 8'h5C;

   typedef enum logic [2:0] {
      W_IDLE,
      W_MAIN,
      W_QUOTE,
      W_SET,
      W_SETQ,
      W_DONE
   } wpm_walk_state_type;

   // one accepted input word as seen by the stores
   typedef struct packed {
      logic       valid;
      logic       kind;      // 0 = pattern byte, 1 = name byte
      logic [7:0] char_val;
   } wpm_load_type;

   typedef struct packed {
      logic matched;
      logic overflow;
   } wpm_result_type;

endpackage

// ===== rtl/wpm_stores.sv =====
// Pattern and name stores: two synchronous RAMs with their fill counts and
// overflow flags. Depends on wpm_pkg.
module wpm_stores
   import wpm_pkg::*;
#(
   parameter int PATTERN_MAX = 64,
   parameter int NAME_MAX    = 256,
   localparam int LW  = $clog2(PATTERN_MAX + 1),
   localparam int PAW = $clog2(PATTERN_MAX),
   localparam int NW  = $clog2(NAME_MAX + 1),
   localparam int NAW = $clog2(NAME_MAX)
) (
   input  logic           clock,
   input  logic           reset,
   input  wpm_load_type   load,
   input  logic           name_clear,
   input  logic [PAW-1:0] pat_raddr,
   input  logic [NAW-1:0] name_raddr,
   output logic [7:0]     pat_rdata,
   output logic [7:0]     name_rdata,
   output logic [LW-1:0]  pat_len,
   output logic [NW-1:0]  name_len,
   output logic           any_ovf
);

   logic [7:0] pat_mem [PATTERN_MAX];
   logic [7:0] name_mem [NAME_MAX];

   logic [7:0] pat_rdata_ff, name_rdata_ff;
   logic [LW-1:0] plen_ff, plen_in, plen_eff;
   logic povf_ff, povf_in, povf_eff;
   logic open_ff, open_in;
   logic [NW-1:0] nlen_ff, nlen_in;
   logic novf_ff, novf_in;
   logic pat_we, name_we;

   // a closed pattern restarts on its next byte
   assign plen_eff = open_ff ? plen_ff : '0;
   assign povf_eff = open_ff & povf_ff;

   always_comb begin
      plen_in = plen_ff;
      povf_in = povf_ff;
      open_in = open_ff;
      nlen_in = nlen_ff;
      novf_in = novf_ff;
      pat_we  = 1'b0;
      name_we = 1'b0;
      if (load.valid && !load.kind) begin
         plen_in = plen_eff;
         povf_in = povf_eff;
         if (load.char_val == CH_NUL) begin
            open_in = 1'b0;
         end else begin
            open_in = 1'b1;
            if (plen_eff < LW'(PATTERN_MAX)) begin
               pat_we  = 1'b1;
               plen_in = plen_eff + LW'(1);
            end else begin
               povf_in = 1'b1;
            end
         end
      end
      if (load.valid && load.kind && load.char_val != CH_NUL) begin
         if (nlen_ff < NW'(NAME_MAX)) begin
            name_we = 1'b1;
            nlen_in = nlen_ff + NW'(1);
         end else begin
            novf_in = 1'b1;
         end
      end
      if (name_clear) begin
         nlen_in = '0;
         novf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
         povf_ff <= 1'b0;
         open_ff <= 1'b0;
         nlen_ff <= '0;
         novf_ff <= 1'b0;
      end else begin
         plen_ff <= plen_in;
         povf_ff <= povf_in;
         open_ff <= open_in;
         nlen_ff <= nlen_in;
         novf_ff <= novf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[plen_eff[PAW-1:0]] <= load.char_val;
      end
      pat_rdata_ff <= pat_mem[pat_raddr];
   end

   always_ff @(posedge clock) begin
      if (name_we) begin
         name_mem[nlen_ff[NAW-1:0]] <= load.char_val;
      end
      name_rdata_ff <= name_mem[name_raddr];
   end

   assign pat_rdata  = pat_rdata_ff;
   assign name_rdata = name_rdata_ff;
   assign pat_len    = plen_ff;
   assign name_len   = nlen_ff;
   assign any_ovf    = povf_ff | novf_ff;

endmodule

// ===== rtl/wpm_walker.sv =====
// Match walker: steps through both stores one comparison per cycle with a
// single retry point. Depends on wpm_pkg; reads RAMs held in wpm_stores.
module wpm_walker
   import wpm_pkg::*;
#(
   parameter int PATTERN_MAX = 64,
   parameter int NAME_MAX    = 256,
   localparam int LW  = $clog2(PATTERN_MAX + 1),
   localparam int PW  = $clog2(PATTERN_MAX + 2),
   localparam int PAW = $clog2(PATTERN_MAX),
   localparam int NW  = $clog2(NAME_MAX + 1),
   localparam int NAW = $clog2(NAME_MAX)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           start_ovf,
   input  logic [LW-1:0]  pat_len,
   input  logic [NW-1:0]  name_len,
   input  logic [7:0]     pat_rdata,
   input  logic [7:0]     name_rdata,
   output logic [PAW-1:0] pat_raddr,
   output logic [NAW-1:0] name_raddr,
   output logic           idle,
   output logic           done,
   input  logic           take,
   output wpm_result_type result
);

   wpm_walk_state_type state_ff, state_in;

   logic [PW-1:0] pi_ff, pi_in, rp_ff, rp_in;
   logic [NW-1:0] ti_ff, ti_in, rt_ff, rt_in;
   logic hr_ff, hr_in;
   logic ok_ff, ok_in;
   logic hit_ff, hit_in;
   logic ovf_ff, ovf_in;

   logic p_end, t_end, char_match;
   logic [7:0] pch, tch;
   logic goto_done, hit_val, res_en, res_ok;

   // RAM data always belongs to the current indices; past the end reads as NUL
   assign p_end      = pi_ff >= PW'(pat_len);
   assign t_end      = ti_ff >= name_len;
   assign pch        = p_end ? CH_NUL : pat_rdata;
   assign tch        = t_end ? CH_NUL : name_rdata;
   assign char_match = tch == pch;

   always_comb begin
      goto_done = 1'b0;
      hit_val   = 1'b0;
      res_en    = 1'b0;
      res_ok    = 1'b0;
      case (state_ff)
         W_MAIN: begin
            if (t_end && p_end) begin
               goto_done = 1'b1;
               hit_val   = 1'b1;
            end else begin
               case (pch)
                  CH_STAR:  ;
                  CH_QUEST: goto_done = t_end;
                  CH_OPEN:  ;
                  CH_QUOTE: ;
                  default: begin
                     res_en = 1'b1;
                     res_ok = char_match;
                  end
               endcase
            end
         end
         W_QUOTE: begin
            if (pch == CH_NUL) begin
               goto_done = 1'b1;
            end else begin
               res_en = 1'b1;
               res_ok = char_match;
            end
         end
         W_SET: begin
            if (pch == CH_CLOSE) begin
               res_en = 1'b1;
               res_ok = ok_ff;
            end else if (pch != CH_QUOTE && pch == CH_NUL) begin
               goto_done = 1'b1;
            end
         end
         W_SETQ: begin
            goto_done = pch == CH_NUL;
         end
         default: ;
      endcase
      // mismatch with nowhere to retry
      if (res_en && !res_ok && (t_end || !hr_ff)) begin
         goto_done = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         W_IDLE: begin
            if (start) begin
               state_in = start_ovf ? W_DONE : W_MAIN;
            end
         end
         W_MAIN: begin
            if (goto_done) begin
               state_in = W_DONE;
            end else if (pch == CH_OPEN) begin
               state_in = W_SET;
            end else if (pch == CH_QUOTE) begin
               state_in = W_QUOTE;
            end
         end
         W_QUOTE: state_in = goto_done ? W_DONE : W_MAIN;
         W_SET: begin
            if (goto_done) begin
               state_in = W_DONE;
            end else if (pch == CH_CLOSE) begin
               state_in = W_MAIN;
            end else if (pch == CH_QUOTE) begin
               state_in = W_SETQ;
            end
         end
         W_SETQ: state_in = goto_done ? W_DONE : W_SET;
         W_DONE: begin
            if (take) begin
               state_in = W_IDLE;
            end
         end
         default: state_in = W_IDLE;
      endcase
   end

   always_comb begin
      pi_in  = pi_ff;
      ti_in  = ti_ff;
      rp_in  = rp_ff;
      rt_in  = rt_ff;
      hr_in  = hr_ff;
      ok_in  = ok_ff;
      hit_in = hit_ff;
      ovf_in = ovf_ff;
      case (state_ff)
         W_IDLE: begin
            if (start) begin
               pi_in  = '0;
               ti_in  = '0;
               rp_in  = '0;
               rt_in  = '0;
               hr_in  = 1'b0;
               hit_in = 1'b0;
               ovf_in = start_ovf;
            end
         end
         W_MAIN: begin
            pi_in = pi_ff + PW'(1);
            case (pch)
               CH_STAR: begin
                  rp_in = pi_ff + PW'(1);
                  rt_in = ti_ff;
                  hr_in = 1'b1;
               end
               CH_QUEST: ti_in = ti_ff + NW'(1);
               CH_OPEN:  ok_in = 1'b0;
               default:  ;
            endcase
         end
         W_QUOTE: pi_in = pi_ff + PW'(1);
         W_SET: begin
            pi_in = pi_ff + PW'(1);
            if (pch != CH_CLOSE && pch != CH_QUOTE && char_match) begin
               ok_in = 1'b1;
            end
         end
         W_SETQ: begin
            pi_in = pi_ff + PW'(1);
            if (char_match) begin
               ok_in = 1'b1;
            end
         end
         default: ;
      endcase
      if (res_en && !goto_done) begin
         if (res_ok) begin
            if (!t_end) begin
               ti_in = ti_ff + NW'(1);
            end
         end else begin
            // back to the star, one name byte further on
            pi_in = rp_ff;
            rt_in = rt_ff + NW'(1);
            ti_in = rt_ff + NW'(1);
         end
      end
      if (goto_done) begin
         hit_in = hit_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         hr_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         hr_ff    <= hr_in;
      end
   end

   always_ff @(posedge clock) begin
      pi_ff  <= pi_in;
      ti_ff  <= ti_in;
      rp_ff  <= rp_in;
      rt_ff  <= rt_in;
      ok_ff  <= ok_in;
      hit_ff <= hit_in;
      ovf_ff <= ovf_in;
   end

   // address the next indices so the registered RAM data lines up with them once they are registered
   assign pat_raddr       = pi_in[PAW-1:0];
   assign name_raddr      = ti_in[NAW-1:0];
   assign idle            = state_ff == W_IDLE;
   assign done            = state_ff == W_DONE;
   assign result.matched  = hit_ff & ~ovf_ff;
   assign result.overflow = ovf_ff;

endmodule

// ===== rtl/wildcard_pattern_matcher.sv =====
// Wildcard (glob) pattern matcher, top level: input handling, result register.
// Depends on wpm_pkg, wpm_stores and wpm_walker.
//
// Input channel req_*: one word per accepted cycle. req_type = 0 loads a
// pattern byte, req_type = 1 a name byte; a zero byte terminates the string.
// A zero pattern byte closes the pattern; the next pattern byte starts anew.
// Loading a pattern or name byte gives no result.
// A zero name byte starts a match walk; req_stall stays high until the
// walk has handed its result to the output register.
// The walk takes one comparison step per pattern byte consumed,
// restarting from the latest star after each mismatch, so
// the worst case is about PATTERN_MAX * NAME_MAX steps. Overflowed words
// skip the walk and report without any comparison step.
// Result channel rsp_*: one word per terminated name, rsp_matched and
// rsp_overflow (overflow forces matched to 0). The output register holds
// while rsp_stall is high; new bytes are taken meanwhile, and a finished
// walk waits for the register to free up.
// Reset clears lengths, flags and the open-pattern state; store contents
// are not cleared and only entries below the lengths are ever used.
module wildcard_pattern_matcher
   import wpm_pkg::*;
#(
   parameter int PATTERN_MAX = 64,
   parameter int NAME_MAX    = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   input  logic [7:0] req_char_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_matched,
   output logic       rsp_overflow
);

   localparam int LW  = $clog2(PATTERN_MAX + 1);
   localparam int PAW = $clog2(PATTERN_MAX);
   localparam int NW  = $clog2(NAME_MAX + 1);
   localparam int NAW = $clog2(NAME_MAX);

   wpm_load_type   load;
   wpm_result_type walk_res;

   logic req_accept, start, walk_idle, walk_done, take, any_ovf;
   logic [PAW-1:0] pat_raddr;
   logic [NAW-1:0] name_raddr;
   logic [7:0] pat_rdata, name_rdata;
   logic [LW-1:0] pat_len;
   logic [NW-1:0] name_len;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_matched_ff, rsp_overflow_ff;

   assign req_stall     = !walk_idle;
   assign req_accept    = req_valid & !req_stall;
   assign load.valid    = req_accept;
   assign load.kind     = req_type;
   assign load.char_val = req_char_value;
   assign start         = req_accept & req_type & (req_char_value == CH_NUL);
   assign take          = walk_done & (!rsp_valid_ff | !rsp_stall);

   wpm_stores #(
      .PATTERN_MAX(PATTERN_MAX),
      .NAME_MAX   (NAME_MAX)
   ) u_stores (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .name_clear(take),
      .pat_raddr (pat_raddr),
      .name_raddr(name_raddr),
      .pat_rdata (pat_rdata),
      .name_rdata(name_rdata),
      .pat_len   (pat_len),
      .name_len  (name_len),
      .any_ovf   (any_ovf)
   );

   wpm_walker #(
      .PATTERN_MAX(PATTERN_MAX),
      .NAME_MAX   (NAME_MAX)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .start_ovf (any_ovf),
      .pat_len   (pat_len),
      .name_len  (name_len),
      .pat_rdata (pat_rdata),
      .name_rdata(name_rdata),
      .pat_raddr (pat_raddr),
      .name_raddr(name_raddr),
      .idle      (walk_idle),
      .done      (walk_done),
      .take      (take),
      .result    (walk_res)
   );

   assign rsp_valid_in = take | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_matched_ff  <= walk_res.matched;
         rsp_overflow_ff <= walk_res.overflow;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_matched  = rsp_matched_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // a walk only begins on a name terminator accepted the cycle before
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_accept && req_type && req_char_value == CH_NUL))
      else $error("walk started without a name terminator");

   a_ovf_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_matched && rsp_overflow))
      else $error("match reported together with overflow");

   a_pat_len: assert property (@(posedge clock) disable iff (reset)
      pat_len <= LW'(PATTERN_MAX))
      else $error("pattern length beyond store");

   a_name_len: assert property (@(posedge clock) disable iff (reset)
      name_len <= NW'(NAME_MAX))
      else $error("name length beyond store");

   // the name store is emptied exactly when a result moves out of the walker
   a_name_clear: assert property (@(posedge clock) disable iff (reset)
      take |=> name_len == '0)
      else $error("name store not emptied after result");

endmodule
